// ----- design/derq_pkg.sv -----
`timescale 1ns / 1ps
package derq_pkg;

    localparam logic CMD_NOTIFY = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    localparam logic [1:0] KIND_ADDED    = 2'd0;
    localparam logic [1:0] KIND_MODIFIED = 2'd1;
    localparam logic [1:0] KIND_REMOVED  = 2'd2;

    localparam int KEY_W  = 32;
    localparam int CAT_W  = 8;
    localparam int KIND_W = 2;
    localparam int NUM_W  = 5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CAT_W-1:0]  category;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic              command;
        logic [KIND_W-1:0] kind;
        logic [CAT_W-1:0]  category;
        logic [KEY_W-1:0]  key;
    } item_t;

    typedef struct packed {
        logic              head_valid;
        logic [KIND_W-1:0] head_kind;
        logic [CAT_W-1:0]  head_category;
        logic [KEY_W-1:0]  head_key;
        logic              updated_in_place;
        logic              dropped_oldest;
        logic [NUM_W-1:0]  removed_count;
        logic [NUM_W-1:0]  fill_level;
    } result_t;

endpackage

// ----- design/derq_mem.sv -----
`timescale 1ns / 1ps
module derq_mem import derq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t store_reg [QUEUE_DEPTH];
    entry_t rdata_reg;

    // controller never reads the slot it writes in the same cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/derq_ctrl.sv -----
`timescale 1ns / 1ps
module derq_ctrl import derq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_POP    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_APPEND = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    item_t         item_reg, item_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_off_reg, pend_off_next;
    logic [CW-1:0] wr_off_reg, wr_off_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic          hv_reg, hv_next;
    entry_t        hentry_reg, hentry_next;
    logic          upd_reg, upd_next;
    logic          drop_reg, drop_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;
    entry_t        item_entry;
    logic          hit, removing;

    // queue offset to physical slot, ring wraps at the depth
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] o);
        logic [AW:0] s;
        s = {1'b0, h} + (AW+1)'(o);
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] h);
        logic [AW-1:0] r;
        if (h == AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = h + 1'b1;
        end
        return r;
    endfunction

    derq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign item_entry = '{kind: item_reg.kind, category: item_reg.category, key: item_reg.key};
    assign hit        = (mem_rdata.key == item_reg.key);
    assign removing   = (item_reg.kind == KIND_REMOVED);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        item_next     = item_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_off_next = pend_off_reg;
        wr_off_next   = wr_off_reg;
        removed_next  = removed_reg;
        hv_next       = hv_reg;
        hentry_next   = hentry_reg;
        upd_next      = upd_reg;
        drop_next     = drop_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = item_entry;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next    = in_item;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    wr_off_next  = '0;
                    removed_next = '0;
                    hv_next      = 1'b0;
                    hentry_next  = '0;
                    upd_next     = 1'b0;
                    drop_next    = 1'b0;
                    state_next   = S_START;
                end
            end
            S_START: begin
                if (item_reg.command == CMD_TAKE) begin
                    if (count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg;
                        state_next = S_POP;
                    end
                end else if (item_reg.kind inside {KIND_ADDED, KIND_MODIFIED}) begin
                    state_next = (count_reg == '0) ? S_APPEND : S_SCAN;
                end else if (removing) begin
                    state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_POP: begin
                hv_next     = 1'b1;
                hentry_next = mem_rdata;
                head_next   = inc(head_reg);
                count_next  = count_reg - 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                // one read issued per cycle, compare on the returned data
                if (rd_idx_reg != count_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = phys(head_reg, rd_idx_reg);
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_off_next = rd_idx_reg;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (removing) begin
                        if (hit) begin
                            removed_next = removed_reg + 1'b1;
                        end else begin
                            // survivors slide down over the deleted slots
                            if (wr_off_reg != pend_off_reg) begin
                                mem_we    = 1'b1;
                                mem_waddr = phys(head_reg, wr_off_reg);
                                mem_wdata = mem_rdata;
                            end
                            wr_off_next = wr_off_reg + 1'b1;
                        end
                        if (rd_idx_reg == count_reg) begin
                            count_next = wr_off_next;
                            state_next = S_DONE;
                        end
                    end else if (hit) begin
                        mem_we     = 1'b1;
                        mem_waddr  = phys(head_reg, pend_off_reg);
                        mem_wdata  = '{kind: item_reg.kind, category: item_reg.category,
                                       key: mem_rdata.key};
                        upd_next   = 1'b1;
                        state_next = S_DONE;
                    end else if (rd_idx_reg == count_reg) begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND: begin
                mem_we = 1'b1;
                if (count_reg == CW'(QUEUE_DEPTH)) begin
                    // full: the new entry takes the oldest one's slot
                    mem_waddr = head_reg;
                    head_next = inc(head_reg);
                    drop_next = 1'b1;
                end else begin
                    mem_waddr  = phys(head_reg, count_reg);
                    count_next = count_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        rd_idx_reg   <= rd_idx_next;
        pend_reg     <= pend_next;
        pend_off_reg <= pend_off_next;
        wr_off_reg   <= wr_off_next;
        removed_reg  <= removed_next;
        hv_reg       <= hv_next;
        hentry_reg   <= hentry_next;
        upd_reg      <= upd_next;
        drop_reg     <= drop_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res.head_valid       = hv_reg;
        res.head_kind        = hentry_reg.kind;
        res.head_category    = hentry_reg.category;
        res.head_key         = hentry_reg.key;
        res.updated_in_place = upd_reg;
        res.dropped_oldest   = drop_reg;
        res.removed_count    = NUM_W'(removed_reg);
        res.fill_level       = NUM_W'(count_reg);
    end

endmodule

// ----- design/dedup_event_request_queue.sv -----
`timescale 1ns / 1ps
// Deduplicating event queue. Each input beat is a notify (added, modified or
// removed event with category and key) or a take, and yields exactly one result
// beat. Entries sit in a ring buffer held in one single-port-read memory, so
// every key match walks the queued entries one per cycle. A take reads only the
// head entry, if any, an added or modified event scans until a key match or the
// end of the queue, a removed event scans the whole queue, and an event of unknown
// kind goes straight to its result. The output register lets a result wait for
// the sink while the next input beat is already being worked on. No clearing
// pass is needed after reset.
module dedup_event_request_queue import derq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // event_category[7:0], event_key[39:8]
    input  logic [2:0]  s_tuser,   // command[0], event_kind[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    // head_kind[1:0], head_category[9:2], head_key[41:10], removed_count[46:42],
    // fill_level[51:47], zero[55:52]
    output logic [55:0] m_tdata,
    output logic [2:0]  m_tuser    // head_valid[0], updated_in_place[1], dropped_oldest[2]
);

    item_t   in_item;
    result_t res;
    result_t out_reg;
    logic    res_valid, res_ready;
    logic    m_tvalid_reg;

    assign in_item = '{command:  s_tuser[0],
                       kind:     s_tuser[2:1],
                       category: s_tdata[7:0],
                       key:      s_tdata[39:8]};

    derq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_reg.fill_level, out_reg.removed_count, out_reg.head_key,
                       out_reg.head_category, out_reg.head_kind};
    assign m_tuser  = {out_reg.dropped_oldest, out_reg.updated_in_place, out_reg.head_valid};

    // a popped entry carries no notify outcome
    a_pop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == 2'b00 && m_tdata[46:42] == 5'd0)
        else $error("take result carries notify flags");

    a_upd_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("update in place and drop both set");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("input accepted while a result is pending");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted before the first was processed");

endmodule
